// File: hw/rtl/cqit_pkg.sv
// ----------------------------------------------------------------------------
// cqit_pkg
// Shared types and constants of the CIGAR query interval trimmer.
// ----------------------------------------------------------------------------
package cqit_pkg;

   localparam int CODE_W = 4;
   localparam int LEN_W  = 28;
   localparam int POS_W  = 30;
   localparam int CSR_W  = 1;

   localparam logic [CSR_W-1:0] CSR_TRIM_START = 1'b0;
   localparam logic [CSR_W-1:0] CSR_TRIM_END   = 1'b1;

   localparam logic [CODE_W-1:0] OP_M  = 4'd0;
   localparam logic [CODE_W-1:0] OP_I  = 4'd1;
   localparam logic [CODE_W-1:0] OP_S  = 4'd4;
   localparam logic [CODE_W-1:0] OP_EQ = 4'd7;
   localparam logic [CODE_W-1:0] OP_X  = 4'd8;

   typedef struct packed {
      logic [CODE_W-1:0] op_code;
      logic [LEN_W-1:0]  op_length;
      logic              record_end;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] out_code;
      logic [LEN_W-1:0]  out_length;
      logic              has_op;
      logic              last_of_record;
      logic              pending_overflow;
   } rsp_type;

   typedef struct packed {
      logic             finish;
      logic             open;
      logic             release_held;
      logic             emit;
      logic             hold;
      logic             overflow;
      logic [LEN_W-1:0] len;
   } decision_type;

   function automatic logic eats_query(input logic [CODE_W-1:0] code);
      eats_query = (code == OP_M) || (code == OP_I) || (code == OP_S) ||
                   (code == OP_EQ) || (code == OP_X);
   endfunction

endpackage

// File: hw/rtl/cqit_step_eval.sv
// ----------------------------------------------------------------------------
// cqit_step_eval
// Per-op decision: cut at interval start or end, pass, hold or drop.
// ----------------------------------------------------------------------------
module cqit_step_eval (
   input  logic [cqit_pkg::POS_W:0]   sum,
   input  logic [cqit_pkg::POS_W-1:0] cursor_prev,
   input  logic [cqit_pkg::POS_W-1:0] ts,
   input  logic [cqit_pkg::POS_W-1:0] te,
   input  logic                       before_ok,
   input  logic                       in_window,
   input  logic                       is_query,
   input  logic                       hold_full,
   input  logic [cqit_pkg::LEN_W-1:0] op_length,
   output cqit_pkg::decision_type     decision
);
   import cqit_pkg::*;

   logic [POS_W:0] cut_end;
   logic [POS_W:0] cut_start;

   function automatic logic [LEN_W-1:0] sat_len(input logic [POS_W:0] v);
      sat_len = (|v[POS_W:LEN_W]) ? {LEN_W{1'b1}} : v[LEN_W-1:0];
   endfunction

   always_comb begin
      decision  = '0;
      cut_end   = in_window ? (before_ok ? {1'b0, te - cursor_prev} : '0) :
                              {1'b0, te - ts};
      cut_start = sum - {1'b0, ts};
      if (sum > {1'b0, te}) begin
         decision.finish = 1'b1;
         if (cut_end != '0) begin
            decision.release_held = 1'b1;
            decision.emit         = 1'b1;
            decision.len          = sat_len(cut_end);
         end
      end else if (sum > {1'b0, ts} && !in_window) begin
         decision.open         = 1'b1;
         decision.release_held = 1'b1;
         decision.emit         = 1'b1;
         decision.len          = sat_len(cut_start);
      end else if (in_window) begin
         if (is_query) begin
            decision.release_held = 1'b1;
            decision.emit         = 1'b1;
            decision.len          = op_length;
         end else if (!hold_full) begin
            decision.hold = 1'b1;
         end else begin
            decision.overflow = 1'b1;
         end
      end
   end

endmodule

// File: hw/rtl/cigar_query_interval_trimmer_unit.sv
// ----------------------------------------------------------------------------
// cigar_query_interval_trimmer_unit
// Trims a record's CIGAR op stream to a query interval, holding non-query ops.
// ----------------------------------------------------------------------------
// one op at a time: accept in IDLE, add in CALC, decide in DECIDE, then each
// result is emitted from OP or TERM, and each held op released is read in REL_RD
// (registered held-op memory read) and emitted in REL_WR; emits wait for a free output slot
// synchronous reset clears control state and config; held-op memory not cleared
module cigar_query_interval_trimmer_unit #(
   parameter int HOLD_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  cqit_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output cqit_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [cqit_pkg::CSR_W-1:0] csr_index,
   input  logic [cqit_pkg::POS_W-1:0] csr_wdata
);
   import cqit_pkg::*;

   localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
   localparam int MEM_W = LEN_W + CODE_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CALC   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_REL_RD = 3'd3;
   localparam logic [2:0] ST_REL_WR = 3'd4;
   localparam logic [2:0] ST_OP     = 3'd5;
   localparam logic [2:0] ST_TERM   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [POS_W-1:0] trim_start_ff, trim_end_ff;
   req_type          in_ff;
   logic [POS_W:0]   sum_ff;
   logic [POS_W-1:0] te_ff;
   logic             before_ok_ff;
   logic [POS_W-1:0] cursor_ff;
   logic             inside_ff, finished_ff, ovf_ff, ovf_out_ff;
   logic [CNT_W-1:0] held_cnt_ff, rel_cnt_ff, rd_idx_ff;
   logic             op_pend_ff, term_pend_ff;
   logic [CODE_W-1:0] op_code_ff;
   logic [LEN_W-1:0] op_len_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             rsp_load;
   logic [MEM_W-1:0] hold_mem [HOLD_DEPTH];
   logic [MEM_W-1:0] mem_rd_ff;

   logic             is_query, hold_full, slot_free, act, ovf_next;
   logic [POS_W-1:0] te_eff;
   decision_type     decision;

   assign is_query  = eats_query(in_ff.op_code);
   assign hold_full = (held_cnt_ff == CNT_W'(HOLD_DEPTH));
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign te_eff    = (trim_end_ff < trim_start_ff) ? trim_start_ff : trim_end_ff;
   assign act       = !finished_ff;
   assign ovf_next  = ovf_ff | (act & decision.overflow);

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cqit_step_eval u_eval (
      .sum         (sum_ff),
      .cursor_prev (cursor_ff),
      .ts          (trim_start_ff),
      .te          (te_ff),
      .before_ok   (before_ok_ff),
      .in_window   (inside_ff),
      .is_query    (is_query),
      .hold_full   (hold_full),
      .op_length   (in_ff.op_length),
      .decision    (decision)
   );

   // sequencer and result loading
   always_comb begin
      state_in    = state_ff;
      rsp_load    = 1'b0;
      rsp_data_in = '0;
      rsp_data_in.pending_overflow = ovf_out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CALC;
         end
         ST_CALC: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (act && decision.release_held && held_cnt_ff != '0) state_in = ST_REL_RD;
            else if (act && decision.emit) state_in = ST_OP;
            else if (in_ff.record_end) state_in = ST_TERM;
            else state_in = ST_IDLE;
         end
         ST_REL_RD: state_in = ST_REL_WR;
         ST_REL_WR: begin
            if (slot_free) begin
               rsp_load               = 1'b1;
               rsp_data_in.out_code   = mem_rd_ff[CODE_W-1:0];
               rsp_data_in.out_length = mem_rd_ff[MEM_W-1:CODE_W];
               rsp_data_in.has_op     = 1'b1;
               if (rd_idx_ff + CNT_W'(1) == rel_cnt_ff) begin
                  if (op_pend_ff) state_in = ST_OP;
                  else if (term_pend_ff) state_in = ST_TERM;
                  else state_in = ST_IDLE;
               end else begin
                  state_in = ST_REL_RD;
               end
            end
         end
         ST_OP: begin
            if (slot_free) begin
               rsp_load               = 1'b1;
               rsp_data_in.out_code   = op_code_ff;
               rsp_data_in.out_length = op_len_ff;
               rsp_data_in.has_op     = 1'b1;
               state_in = term_pend_ff ? ST_TERM : ST_IDLE;
            end
         end
         ST_TERM: begin
            if (slot_free) begin
               rsp_load                   = 1'b1;
               rsp_data_in.last_of_record = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         trim_start_ff <= '0;
         trim_end_ff   <= '0;
         cursor_ff     <= '0;
         inside_ff     <= 1'b0;
         finished_ff   <= 1'b0;
         ovf_ff        <= 1'b0;
         ovf_out_ff    <= 1'b0;
         held_cnt_ff   <= '0;
         rel_cnt_ff    <= '0;
         rd_idx_ff     <= '0;
         op_pend_ff    <= 1'b0;
         term_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_TRIM_START: trim_start_ff <= csr_wdata;
               CSR_TRIM_END:   trim_end_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_DECIDE) begin
            op_pend_ff   <= act && decision.emit;
            term_pend_ff <= in_ff.record_end;
            rd_idx_ff    <= '0;
            ovf_out_ff   <= ovf_next;
            rel_cnt_ff   <= (act && decision.release_held) ? held_cnt_ff : '0;
            if (act && is_query) cursor_ff <= sum_ff[POS_W-1:0];
            if (act && decision.finish) finished_ff <= 1'b1;
            if (act && decision.open) inside_ff <= 1'b1;
            ovf_ff <= ovf_next;
            if (act && decision.release_held) held_cnt_ff <= '0;
            else if (act && decision.hold) held_cnt_ff <= held_cnt_ff + CNT_W'(1);
            if (in_ff.record_end) begin
               cursor_ff   <= '0;
               inside_ff   <= 1'b0;
               finished_ff <= 1'b0;
               ovf_ff      <= 1'b0;
               held_cnt_ff <= '0;
            end
         end
         if (state_ff == ST_REL_WR && slot_free) rd_idx_ff <= rd_idx_ff + CNT_W'(1);
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_ff <= req_data;
      if (state_ff == ST_CALC) begin
         sum_ff       <= {1'b0, cursor_ff} +
                         (is_query ? (POS_W+1)'(in_ff.op_length) : '0);
         te_ff        <= te_eff;
         before_ok_ff <= (cursor_ff <= trim_end_ff) || (cursor_ff <= trim_start_ff);
      end
      if (state_ff == ST_DECIDE) begin
         op_code_ff <= in_ff.op_code;
         op_len_ff  <= decision.len;
      end
      if (rsp_load) rsp_data_ff <= rsp_data_in;
   end

   // held-op memory
   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE && act && decision.hold)
         hold_mem[held_cnt_ff[IDX_W-1:0]] <= {in_ff.op_length, in_ff.op_code};
      if (state_ff == ST_REL_RD) mem_rd_ff <= hold_mem[rd_idx_ff[IDX_W-1:0]];
   end

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff <= CNT_W'(HOLD_DEPTH))
      else $error("held count above depth");

   a_held_inside: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff != '0 |-> inside_ff)
      else $error("ops held outside interval");

   a_term_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TERM) && slot_free |=>
         rsp_valid_ff && rsp_data_ff.last_of_record && !rsp_data_ff.has_op)
      else $error("terminator transaction not loaded");

   a_rel_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REL_RD) |-> (rel_cnt_ff != '0) && (rd_idx_ff < rel_cnt_ff))
      else $error("release beyond held ops");

endmodule
